// File: rtl/core/lca_pkg.sv
// Shared types, constants and saturating helpers for the leader clustering block.
package lca_pkg;

  localparam int MAX_CLUSTERS = 64;
  localparam int IDX_W        = $clog2(MAX_CLUSTERS);
  localparam int NUM_W        = IDX_W + 1;
  localparam int CX_W         = 25;
  localparam int CY_W         = 24;
  localparam int SX_W         = 45;
  localparam int SY_W         = 44;
  localparam int PC_W         = 21;
  localparam int LIM_W        = 50;
  localparam int DX_W         = CX_W + 1;
  localparam int DY_W         = CY_W + 1;
  localparam int DIST_W       = 2 * DX_W + 1;

  localparam logic [PC_W-1:0]  MAX_POINTS  = PC_W'(1048576);
  localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(64'd4294967296);

  localparam logic OP_ITEM       = 1'b0;
  localparam logic OP_END        = 1'b1;
  localparam logic KIND_ASSIGN   = 1'b0;
  localparam logic KIND_REPORT   = 1'b1;
  localparam logic REG_LIMIT     = 1'b0;

  typedef struct packed {
    logic signed [CX_W-1:0] x;
    logic signed [CY_W-1:0] y;
    logic signed [SX_W-1:0] ax;
    logic signed [SY_W-1:0] ay;
    logic [PC_W-1:0]        cnt;
  } entry_t;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] idx;
  } tag_t;

  function automatic logic signed [SX_W-1:0] sat_add_x(input logic signed [SX_W-1:0] a,
                                                       input logic signed [SX_W-1:0] b);
    logic signed [SX_W:0] s;
    s = {a[SX_W-1], a} + {b[SX_W-1], b};
    if (s[SX_W] != s[SX_W-1]) begin
      return s[SX_W] ? {1'b1, {(SX_W-1){1'b0}}} : {1'b0, {(SX_W-1){1'b1}}};
    end
    return s[SX_W-1:0];
  endfunction

  function automatic logic signed [SY_W-1:0] sat_add_y(input logic signed [SY_W-1:0] a,
                                                       input logic signed [SY_W-1:0] b);
    logic signed [SY_W:0] s;
    s = {a[SY_W-1], a} + {b[SY_W-1], b};
    if (s[SY_W] != s[SY_W-1]) begin
      return s[SY_W] ? {1'b1, {(SY_W-1){1'b0}}} : {1'b0, {(SY_W-1){1'b1}}};
    end
    return s[SY_W-1:0];
  endfunction

  function automatic logic [PC_W-1:0] sat_count(input logic [PC_W-1:0] a,
                                                input logic [PC_W-1:0] b);
    logic [PC_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s > {1'b0, MAX_POINTS}) begin
      return MAX_POINTS;
    end
    return s[PC_W-1:0];
  endfunction

endpackage

// File: rtl/core/lca_cell.sv
// One table entry of the rotating cluster ring.
module lca_cell (
  input  logic            clk,
  input  logic            shift,
  input  lca_pkg::entry_t d,
  output lca_pkg::entry_t q
);

  always_ff @(posedge clk) begin
    if (shift) begin
      q <= d;
    end
  end

endmodule

// File: rtl/core/lca_dist.sv
// Pipelined squared-distance unit with running nearest-entry search.
module lca_dist (
  input  logic                           clk,
  input  logic                           rst,
  input  lca_pkg::tag_t                  tag,
  input  logic signed [lca_pkg::CX_W-1:0] cx,
  input  logic signed [lca_pkg::CY_W-1:0] cy,
  input  logic signed [lca_pkg::CX_W-1:0] lx,
  input  logic signed [lca_pkg::CY_W-1:0] ly,
  output logic [lca_pkg::IDX_W-1:0]      best_idx,
  output logic [lca_pkg::DIST_W-1:0]     best_d
);

  logic signed [lca_pkg::DX_W-1:0]  diff_x;
  logic signed [lca_pkg::DY_W-1:0]  diff_y;
  logic [lca_pkg::DX_W-1:0]         dx;
  logic [lca_pkg::DY_W-1:0]         dy;
  lca_pkg::tag_t                    tag1;
  logic [2*lca_pkg::DX_W-1:0]       sq_x;
  logic [2*lca_pkg::DY_W-1:0]       sq_y;
  lca_pkg::tag_t                    tag2;
  logic [lca_pkg::DIST_W-1:0]       dist_sum;

  assign diff_x   = {cx[lca_pkg::CX_W-1], cx} - {lx[lca_pkg::CX_W-1], lx};
  assign diff_y   = {cy[lca_pkg::CY_W-1], cy} - {ly[lca_pkg::CY_W-1], ly};
  assign dist_sum = {1'b0, sq_x} + lca_pkg::DIST_W'(sq_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      tag1.valid <= 1'b0;
      tag2.valid <= 1'b0;
    end else begin
      tag1.valid <= tag.valid;
      tag2.valid <= tag1.valid;
    end
    tag1.idx <= tag.idx;
    tag2.idx <= tag1.idx;
    dx   <= diff_x[lca_pkg::DX_W-1] ? lca_pkg::DX_W'(-diff_x) : lca_pkg::DX_W'(diff_x);
    dy   <= diff_y[lca_pkg::DY_W-1] ? lca_pkg::DY_W'(-diff_y) : lca_pkg::DY_W'(diff_y);
    sq_x <= dx * dx;
    sq_y <= dy * dy;
    // first entry seeds the search, later ones win only when strictly nearer
    if (tag2.valid && ((tag2.idx == '0) || (dist_sum < best_d))) begin
      best_d   <= dist_sum;
      best_idx <= tag2.idx;
    end
  end

endmodule

// File: rtl/core/lca_div.sv
// Bit-serial restoring divider: signed dividend by unsigned count, truncating.
module lca_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic signed [lca_pkg::SX_W-1:0] dividend,
  input  logic [lca_pkg::PC_W-1:0]        divisor,
  output logic                            done,
  output logic                            neg,
  output logic [lca_pkg::SX_W-1:0]        quot
);

  localparam int STEP_W = $clog2(lca_pkg::SX_W);

  logic                       busy;
  logic [STEP_W-1:0]          step;
  logic [lca_pkg::PC_W-1:0]   rem;
  logic [lca_pkg::PC_W-1:0]   dvs;
  logic [lca_pkg::PC_W:0]     trial;
  logic                       ge;

  assign trial = {rem, quot[lca_pkg::SX_W-1]};
  assign ge    = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (step == STEP_W'(lca_pkg::SX_W - 1))) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
    if (start) begin
      neg  <= dividend[lca_pkg::SX_W-1];
      quot <= dividend[lca_pkg::SX_W-1] ? lca_pkg::SX_W'(-dividend)
                                        : lca_pkg::SX_W'(dividend);
      dvs  <= divisor;
      rem  <= '0;
      step <= '0;
    end else if (busy) begin
      rem  <= ge ? lca_pkg::PC_W'(trial - {1'b0, dvs}) : trial[lca_pkg::PC_W-1:0];
      quot <= {quot[lca_pkg::SX_W-2:0], ge};
      step <= step + 1'b1;
    end
  end

endmodule

// File: rtl/core/leader_cluster_assign.sv
// Top level of the leader clustering block: ring of table cells plus sequencer.
//
// Usage: set distance_sq_limit over the APB port (64-bit register at byte
// address 0; reset value 2^32), then issue transactions with start while busy
// is low. op=0 carries a point cluster; op=1 closes the pass.
// An op=0 transaction rotates the 64-entry ring once past the distance unit,
// drains the 3-stage distance pipeline, rotates once more to merge or write
// the chosen entry and then strobes one assignment result; busy stays high
// meanwhile, so no new item is taken before that result. An op=1
// transaction strobes one center report per cluster in use; each needs one
// pass of the bit-serial dividers. An empty table gives one report with
// total_count 0 right away. Each result appears for one cycle with
// result_valid high; last marks the final result of a transaction. The
// receiver cannot stall, so results are never held back. Reset empties the
// table and restores the limit; entry contents are not cleared and no
// clearing pass runs.
module leader_cluster_assign (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [3:0]                          paddr,
  input  logic [63:0]                         pwdata,
  output logic [63:0]                         prdata,
  output logic                                pready,
  input  logic                                start,
  output logic                                busy,
  input  logic                                op,
  input  logic signed [lca_pkg::CX_W-1:0]     center_x,
  input  logic signed [lca_pkg::CY_W-1:0]     center_y,
  input  logic signed [lca_pkg::SX_W-1:0]     sum_x,
  input  logic signed [lca_pkg::SY_W-1:0]     sum_y,
  input  logic [lca_pkg::PC_W-1:0]            point_count,
  output logic                                result_valid,
  output logic                                kind,
  output logic [lca_pkg::IDX_W-1:0]           cluster_index,
  output logic                                is_new,
  output logic                                table_full,
  output logic signed [lca_pkg::CX_W-1:0]     mean_x,
  output logic signed [lca_pkg::CY_W-1:0]     mean_y,
  output logic [lca_pkg::PC_W-1:0]            total_count,
  output logic                                last
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SCAN   = 6'b000010,
    S_DRAIN  = 6'b000100,
    S_UPDATE = 6'b001000,
    S_LOAD   = 6'b010000,
    S_DIV    = 6'b100000
  } state_t;

  localparam int LAST_CELL = lca_pkg::MAX_CLUSTERS - 1;

  state_t                            state;
  logic [lca_pkg::LIM_W-1:0]         distance_sq_limit;
  logic [lca_pkg::NUM_W-1:0]         clusters_in_use;
  logic [lca_pkg::NUM_W-1:0]         step;
  logic                              shift;
  lca_pkg::entry_t                   ring_q [lca_pkg::MAX_CLUSTERS];
  lca_pkg::entry_t                   feedback;
  lca_pkg::entry_t                   item;
  lca_pkg::entry_t                   merged;
  lca_pkg::tag_t                     tag;
  logic [lca_pkg::IDX_W-1:0]         best_idx;
  logic [lca_pkg::DIST_W-1:0]        best_d;
  logic                              far;
  logic                              join_new;
  logic                              join_full;
  logic [lca_pkg::IDX_W-1:0]         target;
  logic                              div_start;
  logic                              done_x;
  logic                              done_y;
  logic                              neg_x;
  logic                              neg_y;
  logic [lca_pkg::SX_W-1:0]          quot_x;
  logic [lca_pkg::SX_W-1:0]          quot_y;
  logic signed [lca_pkg::CX_W-1:0]   clamp_x;
  logic signed [lca_pkg::CY_W-1:0]   clamp_y;
  logic                              accept;
  logic                              report_last;

  // APB: one register, always ready
  assign pready = 1'b1;
  assign prdata = (paddr[3] == lca_pkg::REG_LIMIT) ? 64'(distance_sq_limit) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      distance_sq_limit <= lca_pkg::LIMIT_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[3] == lca_pkg::REG_LIMIT)) begin
      distance_sq_limit <= pwdata[lca_pkg::LIM_W-1:0];
    end
  end

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // Ring: each cell takes its upper neighbor; the top cell takes the head back.
  assign shift = (state == S_SCAN) || (state == S_UPDATE) || ((state == S_DIV) && done_x);

  for (genvar k = 0; k < lca_pkg::MAX_CLUSTERS; k++) begin : g_ring
    if (k == LAST_CELL) begin : g_top
      lca_cell u_cell (.clk(clk), .shift(shift), .d(feedback), .q(ring_q[k]));
    end else begin : g_mid
      lca_cell u_cell (.clk(clk), .shift(shift), .d(ring_q[k+1]), .q(ring_q[k]));
    end
  end

  // Merge the item into the head entry, or replace it with a fresh cluster.
  always_comb begin
    merged     = ring_q[0];
    merged.ax  = lca_pkg::sat_add_x(ring_q[0].ax, item.ax);
    merged.ay  = lca_pkg::sat_add_y(ring_q[0].ay, item.ay);
    merged.cnt = lca_pkg::sat_count(ring_q[0].cnt, item.cnt);
    feedback   = ring_q[0];
    if ((state == S_UPDATE) && (step[lca_pkg::IDX_W-1:0] == target)) begin
      feedback = is_new ? item : merged;
    end
  end

  // Distance search sees the head entry during the scan rotation.
  assign tag.valid = (state == S_SCAN) && (step < clusters_in_use);
  assign tag.idx   = step[lca_pkg::IDX_W-1:0];

  lca_dist u_dist (
    .clk(clk), .rst(rst), .tag(tag),
    .cx(item.x), .cy(item.y), .lx(ring_q[0].x), .ly(ring_q[0].y),
    .best_idx(best_idx), .best_d(best_d)
  );

  assign far       = (clusters_in_use == '0) ||
                     (best_d > lca_pkg::DIST_W'(distance_sq_limit));
  assign join_new  = far && (clusters_in_use < lca_pkg::NUM_W'(lca_pkg::MAX_CLUSTERS));
  assign join_full = far && !join_new;

  // Mean dividers run on the head entry.
  assign div_start = (state == S_LOAD);

  lca_div u_div_x (
    .clk(clk), .rst(rst), .start(div_start), .dividend(ring_q[0].ax),
    .divisor(ring_q[0].cnt), .done(done_x), .neg(neg_x), .quot(quot_x)
  );

  lca_div u_div_y (
    .clk(clk), .rst(rst), .start(div_start),
    .dividend(lca_pkg::SX_W'(ring_q[0].ay)),
    .divisor(ring_q[0].cnt), .done(done_y), .neg(neg_y), .quot(quot_y)
  );

  // Clamp quotients into the mean field ranges.
  always_comb begin
    if (neg_x) begin
      clamp_x = (quot_x > lca_pkg::SX_W'(1 << (lca_pkg::CX_W - 1)))
              ? {1'b1, {(lca_pkg::CX_W-1){1'b0}}} : lca_pkg::CX_W'(-quot_x);
    end else begin
      clamp_x = (quot_x > lca_pkg::SX_W'((1 << (lca_pkg::CX_W - 1)) - 1))
              ? {1'b0, {(lca_pkg::CX_W-1){1'b1}}} : quot_x[lca_pkg::CX_W-1:0];
    end
    if (neg_y) begin
      clamp_y = (quot_y > lca_pkg::SX_W'(1 << (lca_pkg::CY_W - 1)))
              ? {1'b1, {(lca_pkg::CY_W-1){1'b0}}} : lca_pkg::CY_W'(-quot_y);
    end else begin
      clamp_y = (quot_y > lca_pkg::SX_W'((1 << (lca_pkg::CY_W - 1)) - 1))
              ? {1'b0, {(lca_pkg::CY_W-1){1'b1}}} : quot_y[lca_pkg::CY_W-1:0];
    end
  end

  assign report_last = ((step + 1'b1) == clusters_in_use);

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      clusters_in_use <= '0;
      step            <= '0;
      result_valid    <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          step <= '0;
          if (accept) begin
            if (op == lca_pkg::OP_ITEM) begin
              state <= S_SCAN;
            end else if (clusters_in_use == '0) begin
              result_valid <= 1'b1;
            end else begin
              state <= S_LOAD;
            end
          end
        end
        S_SCAN: begin
          // advance one entry per cycle through the distance unit
          step <= step + 1'b1;
          if (step == lca_pkg::NUM_W'(LAST_CELL)) begin
            step  <= '0;
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          // hold until the last distance reaches the search register
          step <= step + 1'b1;
          if (step == lca_pkg::NUM_W'(2)) begin
            step  <= '0;
            state <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          step <= step + 1'b1;
          if (step == lca_pkg::NUM_W'(LAST_CELL)) begin
            step         <= '0;
            state        <= S_IDLE;
            result_valid <= 1'b1;
            if (is_new) begin
              clusters_in_use <= clusters_in_use + 1'b1;
            end
          end
        end
        S_LOAD: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (done_x) begin
            result_valid <= 1'b1;
            step         <= step + 1'b1;
            state        <= S_LOAD;
            if (report_last) begin
              // drop the whole table once the final center goes out
              clusters_in_use <= '0;
              step            <= '0;
              state           <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Latch the transaction payload and the placement decision.
  always_ff @(posedge clk) begin
    if (accept) begin
      item.x   <= center_x;
      item.y   <= center_y;
      item.ax  <= sum_x;
      item.ay  <= sum_y;
      item.cnt <= (point_count > lca_pkg::MAX_POINTS) ? lca_pkg::MAX_POINTS : point_count;
    end
    if ((state == S_DRAIN) && (step == lca_pkg::NUM_W'(2))) begin
      is_new     <= join_new;
      table_full <= join_full;
      target     <= join_new ? clusters_in_use[lca_pkg::IDX_W-1:0] : best_idx;
    end
    if (accept && (op == lca_pkg::OP_END)) begin
      is_new     <= 1'b0;
      table_full <= 1'b0;
    end
  end

  // Result registers; valid only in the strobe cycle.
  always_ff @(posedge clk) begin
    if (accept && (op == lca_pkg::OP_END) && (clusters_in_use == '0)) begin
      kind          <= lca_pkg::KIND_REPORT;
      cluster_index <= '0;
      mean_x        <= '0;
      mean_y        <= '0;
      total_count   <= '0;
      last          <= 1'b1;
    end else if ((state == S_UPDATE) && (step == lca_pkg::NUM_W'(LAST_CELL))) begin
      kind          <= lca_pkg::KIND_ASSIGN;
      cluster_index <= target;
      mean_x        <= '0;
      mean_y        <= '0;
      total_count   <= '0;
      last          <= 1'b1;
    end else if ((state == S_DIV) && done_x) begin
      kind          <= lca_pkg::KIND_REPORT;
      cluster_index <= step[lca_pkg::IDX_W-1:0];
      mean_x        <= (ring_q[0].cnt == '0) ? '0 : clamp_x;
      mean_y        <= (ring_q[0].cnt == '0) ? '0 : clamp_y;
      total_count   <= ring_q[0].cnt;
      last          <= report_last;
    end
  end

  // y divider runs in lockstep with x; its done is not needed separately
  logic unused_done_y;
  assign unused_done_y = done_y;

endmodule
